[sv/nlqdc_pkg.sv]
// nlqdc_pkg: widths, register indexes and reset values for the
// dead-zone dequantizer and layer combiner; used by nlq_deadzone_layer_combiner
package nlqdc_pkg;

   localparam int BASE_W  = 16;
   localparam int ENH_W   = 10;
   localparam int OUT_W   = 15;
   localparam int COEF_W  = 32;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ENH_OFFSET    = 3'd0;
   localparam logic [IDX_W-1:0] REG_SLOPE         = 3'd1;
   localparam logic [IDX_W-1:0] REG_THRESHOLD     = 3'd2;
   localparam logic [IDX_W-1:0] REG_RESID_LIMIT   = 3'd3;
   localparam logic [IDX_W-1:0] REG_COEFF_LOG2    = 3'd4;
   localparam logic [IDX_W-1:0] REG_ENH_DEPTH     = 3'd5;
   localparam logic [IDX_W-1:0] REG_OUT_DEPTH     = 3'd6;
   localparam logic [IDX_W-1:0] REG_RESIDUAL_OFF  = 3'd7;

   // reset values
   localparam logic [9:0] RST_ENH_OFFSET = 10'd512;
   localparam logic [5:0] RST_COEFF_LOG2 = 6'd23;
   localparam logic [3:0] RST_ENH_DEPTH  = 4'd10;
   localparam logic [3:0] RST_OUT_DEPTH  = 4'd12;

   // fixed scale points of the dequantizer
   localparam logic [3:0] UP_REF     = 4'd10;
   localparam logic [3:0] THR_REF    = 4'd11;
   localparam logic [4:0] DOWN_BIAS  = 5'd5;
   localparam logic [3:0] RND_REF    = 4'd15;
   localparam logic [4:0] SHIFT_REF  = 5'd16;

endpackage

[sv/nlq_deadzone_layer_combiner.sv]
// nlq_deadzone_layer_combiner: five-stage pipeline that dequantizes the
// enhancement word with a linear dead zone and adds it to the base word.
// Depends on nlqdc_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_base_sample, req_enh_sample
//   rsp      out        rsp_valid / rsp_ready  rsp_out_sample
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One word enters per cycle while the pipeline is not stalled; a taken word
// passes through the stages: scale, multiply, threshold and clamp, down
// shift and sum, round and clamp to the output depth.
// Each stage holds its word while the one after it is full and stalled,
// so a stall loses nothing and empty stages still fill.
// reset (synchronous, active high) empties the pipeline and loads the
// register reset values.
module nlq_deadzone_layer_combiner
   import nlqdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BASE_W-1:0]   req_base_sample,
   input  logic [ENH_W-1:0]    req_enh_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_W-1:0]    rsp_out_sample,
   input  logic                csr_wr_en,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   // configuration registers
   logic [9:0]        enh_offset_ff;
   logic [COEF_W-1:0] slope_ff;
   logic [COEF_W-1:0] threshold_ff;
   logic [COEF_W-1:0] resid_limit_ff;
   logic [5:0]        coeff_log2_ff;
   logic [3:0]        enh_depth_ff;
   logic [3:0]        out_depth_ff;
   logic              residual_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enh_offset_ff   <= RST_ENH_OFFSET;
         slope_ff        <= '0;
         threshold_ff    <= '0;
         resid_limit_ff  <= '0;
         coeff_log2_ff   <= RST_COEFF_LOG2;
         enh_depth_ff    <= RST_ENH_DEPTH;
         out_depth_ff    <= RST_OUT_DEPTH;
         residual_off_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENH_OFFSET:   enh_offset_ff   <= csr_wdata[9:0];
            REG_SLOPE:        slope_ff        <= csr_wdata;
            REG_THRESHOLD:    threshold_ff    <= csr_wdata;
            REG_RESID_LIMIT:  resid_limit_ff  <= csr_wdata;
            REG_COEFF_LOG2:   coeff_log2_ff   <= csr_wdata[5:0];
            REG_ENH_DEPTH:    enh_depth_ff    <= csr_wdata[3:0];
            REG_OUT_DEPTH:    out_depth_ff    <= csr_wdata[3:0];
            REG_RESIDUAL_OFF: residual_off_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // shift amounts, negative ones count as zero
   logic [3:0] up_amt;
   logic [3:0] thr_amt;
   logic [4:0] down_bias;
   logic [5:0] down_amt;
   logic [3:0] rnd_amt;
   logic [4:0] fin_amt;
   logic [15:0] max_out;

   assign up_amt    = (enh_depth_ff >= UP_REF) ? 4'd0 : UP_REF - enh_depth_ff;
   assign thr_amt   = (enh_depth_ff >= THR_REF) ? 4'd0 : THR_REF - enh_depth_ff;
   assign down_bias = DOWN_BIAS + {1'b0, enh_depth_ff};
   assign down_amt  = (coeff_log2_ff > {1'b0, down_bias}) ?
                      coeff_log2_ff - {1'b0, down_bias} : 6'd0;
   assign rnd_amt   = RND_REF - out_depth_ff;
   assign fin_amt   = SHIFT_REF - {1'b0, out_depth_ff};
   assign max_out   = (16'd1 << out_depth_ff) - 16'd1;

   // stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5      = !v5_ff || rsp_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // stage 1: offset, dead-zone step and precision scaling
   logic signed [10:0] diff_in;
   logic signed [11:0] dbl_in;
   logic signed [21:0] tsc_in;
   logic [42:0]        thr_in;
   logic [42:0]        rr_in;
   logic               neg_in;
   logic               nz_in;

   logic signed [21:0] tsc_s1_ff;
   logic [42:0]        thr_s1_ff;
   logic [42:0]        rr_s1_ff;
   logic               neg_s1_ff;
   logic               nz_s1_ff;
   logic [BASE_W-1:0]  base_s1_ff;

   always_comb begin
      diff_in = $signed({1'b0, req_enh_sample} - {1'b0, enh_offset_ff});
      neg_in  = diff_in[10];
      nz_in   = (diff_in != 11'sd0) && !residual_off_ff;
      // 2t moved one step toward zero
      dbl_in  = $signed({diff_in, 1'b0}) + (neg_in ? 12'sd1 : -12'sd1);
      tsc_in  = $signed({{10{dbl_in[11]}}, dbl_in}) <<< up_amt;
      thr_in  = {11'd0, threshold_ff} << thr_amt;
      rr_in   = {11'd0, resid_limit_ff} << thr_amt;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         tsc_s1_ff  <= tsc_in;
         thr_s1_ff  <= thr_in;
         rr_s1_ff   <= rr_in;
         neg_s1_ff  <= neg_in;
         nz_s1_ff   <= nz_in;
         base_s1_ff <= req_base_sample;
      end
   end

   // stage 2: slope multiply
   logic signed [54:0] prod_in;
   logic signed [54:0] prod_s2_ff;
   logic [42:0]        thr_s2_ff;
   logic [42:0]        rr_s2_ff;
   logic               neg_s2_ff;
   logic               nz_s2_ff;
   logic [BASE_W-1:0]  base_s2_ff;

   assign prod_in = tsc_s1_ff * $signed({1'b0, slope_ff});

   always_ff @(posedge clock) begin
      if (rdy2) begin
         prod_s2_ff <= prod_in;
         thr_s2_ff  <= thr_s1_ff;
         rr_s2_ff   <= rr_s1_ff;
         neg_s2_ff  <= neg_s1_ff;
         nz_s2_ff   <= nz_s1_ff;
         base_s2_ff <= base_s1_ff;
      end
   end

   // stage 3: signed threshold and clamp to the residual limit
   logic signed [43:0] thr_sgn;
   logic signed [55:0] sum_in;
   logic signed [55:0] rr_pos;
   logic signed [44:0] dq_in;
   logic signed [44:0] dq_s3_ff;
   logic               nz_s3_ff;
   logic [BASE_W-1:0]  base_s3_ff;

   always_comb begin
      thr_sgn = neg_s2_ff ? -$signed({1'b0, thr_s2_ff}) : $signed({1'b0, thr_s2_ff});
      sum_in  = prod_s2_ff + thr_sgn;
      rr_pos  = $signed({13'd0, rr_s2_ff});
      if (sum_in > rr_pos) begin
         dq_in = rr_pos[44:0];
      end else if (sum_in < -rr_pos) begin
         dq_in = -rr_pos[44:0];
      end else begin
         dq_in = sum_in[44:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         dq_s3_ff   <= dq_in;
         nz_s3_ff   <= nz_s2_ff;
         base_s3_ff <= base_s2_ff;
      end
   end

   // stage 4: down shift, add base and rounding offset
   logic signed [44:0] res_sh;
   logic [46:0]        res_ext;
   logic [46:0]        rnd;
   logic [46:0]        h_in;
   logic [46:0]        h_s4_ff;

   always_comb begin
      res_sh  = dq_s3_ff >>> down_amt;
      res_ext = nz_s3_ff ? {{2{res_sh[44]}}, res_sh} : 47'd0;
      rnd     = 47'd1 << rnd_amt;
      h_in    = res_ext + {31'd0, base_s3_ff} + rnd;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         h_s4_ff <= h_in;
      end
   end

   // stage 5: round down to the output depth and clamp
   logic signed [46:0] h_sh;
   logic [OUT_W-1:0]   out_in;
   logic [OUT_W-1:0]   out_s5_ff;

   always_comb begin
      h_sh = $signed(h_s4_ff) >>> fin_amt;
      if (h_sh[46]) begin
         out_in = '0;
      end else if (h_sh > $signed({31'd0, max_out})) begin
         out_in = max_out[OUT_W-1:0];
      end else begin
         out_in = h_sh[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         out_s5_ff <= out_in;
      end
   end

   assign rsp_out_sample = out_s5_ff;

`ifndef ASSERT_OFF
   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_out_sample} <= max_out))
      else $error("output word above the output depth maximum");

   a_dq_clamped: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((dq_s3_ff <= $signed({2'b0, rr_s2_ff})) &&
                 (dq_s3_ff >= -$signed({2'b0, rr_s2_ff}))))
      else $error("dequantized residual outside its limit");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && rdy2) |=> v2_ff)
      else $error("word lost between stage one and stage two");

   a_out_advance: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rdy5) |=> rsp_valid)
      else $error("word lost before the output register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !v1_ff && !v4_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
